/* design/assert_macros.svh */
// Assertion macros used by the checker module of this project.
// Depends on nothing; both macros need clk in scope, ASSERT_CLK also rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk and switched off while rst is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent assertion sampled on clk that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* design/fic_pkg.sv */
// Shared constants, types and status codes of the firmware image CRC checker.
// Depends on nothing; imported by every module of the block.
package fic_pkg;

  localparam int unsigned WORD_W   = 24;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CRC_W    = 32;
  localparam int unsigned IDX_W    = 17;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  // Destination plus 4*ceil(length/2) without wrap.
  localparam int unsigned END_W    = WORD_W + 1;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] VERSION_RESET = 24'd1;
  localparam logic [WORD_W-1:0] LIMIT_RESET   = 24'h00_AF00;

  // Word positions inside an image.
  localparam logic [IDX_W-1:0] IDX_VERSION = 17'd1;
  localparam logic [IDX_W-1:0] IDX_DEST    = 17'd2;
  localparam logic [IDX_W-1:0] IDX_HEADER  = 17'd3;

  // Register indexes on the configuration port.
  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_VER  = 2'd1,
    STATUS_BAD_CRC  = 2'd2,
    STATUS_BAD_DEST = 2'd3
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] expected_version;
    logic [WORD_W-1:0] address_limit;
  } cfg_t;

endpackage

/* design/fic_regs.sv */
// APB-style configuration registers: expected version and address limit.
// Depends on fic_pkg.
module fic_regs
  import fic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic wr_en;

  // A write completes in the access phase; pready is always high.
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= VERSION_RESET;
      cfg.address_limit    <= LIMIT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_VERSION) begin
        cfg.expected_version <= pwdata[WORD_W-1:0];
      end else begin
        cfg.address_limit <= pwdata[WORD_W-1:0];
      end
    end
  end

  // Read data, zero extended to the bus width.
  always_comb begin
    if (paddr[2] == REG_LIMIT) begin
      prdata = {{(DATA_W-WORD_W){1'b0}}, cfg.address_limit};
    end else begin
      prdata = {{(DATA_W-WORD_W){1'b0}}, cfg.expected_version};
    end
  end

endmodule

/* design/fic_crc_step.sv */
// One word of the reflected CRC-32: the 24 shift steps flatten into an XOR network.
// Depends on fic_pkg.
module fic_crc_step
  import fic_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [WORD_W-1:0] word,
  output logic [CRC_W-1:0]  crc_out
);

  // The word enters the low bits first, then one LFSR shift per word bit.
  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-WORD_W){1'b0}}, word};
    for (int k = 0; k < WORD_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

/* design/fic_tracker.sv */
// Image tracker: input register, per-image state, checks and result register.
// Depends on fic_pkg and fic_crc_step.
module fic_tracker
  import fic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic [WORD_W-1:0] word,
  input  logic              start_req,
  input  logic              word_valid,
  output logic              word_stall,
  output logic [1:0]        status,
  output logic [WORD_W-1:0] computed_crc,
  output logic [WORD_W-1:0] destination,
  output logic [LEN_W-1:0]  length,
  output logic              result_valid,
  input  logic              result_stall
);

  // Input register.
  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_start;

  // Image state.
  logic              active;
  logic [IDX_W-1:0]  word_index;
  logic [CRC_W-1:0]  crc_reg;
  logic [WORD_W-1:0] image_crc;
  logic              version_bad;
  logic [WORD_W-1:0] dest_addr;
  logic [LEN_W-1:0]  payload_length;

  logic              word_take;
  logic              advance;
  logic              process;
  logic              done;
  logic [CRC_W-1:0]  crc_next;
  logic [LEN_W-1:0]  len_cur;
  logic [WORD_W-1:0] dest_cur;
  logic              ver_bad_cur;
  logic [WORD_W-1:0] fin_crc;
  logic [END_W-1:0]  end_addr;
  status_t           status_next;

  // The held word moves on unless a finished result is still stalled.
  assign advance    = in_valid && !(result_valid && result_stall);
  assign word_stall = in_valid && !advance;
  assign word_take  = word_valid && !word_stall;
  assign process    = advance && !in_start && active;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (word_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      in_word  <= word;
      in_start <= start_req;
    end
  end

  fic_crc_step u_crc (
    .crc_in  (crc_reg),
    .word    (in_word),
    .crc_out (crc_next)
  );

  // Header fields as they stand after this word.
  always_comb begin
    len_cur     = (word_index == IDX_HEADER) ? in_word[LEN_W-1:0] : payload_length;
    dest_cur    = (word_index == IDX_DEST) ? in_word : dest_addr;
    ver_bad_cur = (word_index == IDX_VERSION) ? (in_word != cfg.expected_version)
                                              : version_bad;
    done        = (word_index >= IDX_HEADER) &&
                  (word_index == ({1'b0, len_cur} + IDX_HEADER));
    fin_crc     = ~crc_next[WORD_W-1:0];
    end_addr    = {1'b0, dest_cur} +
                  END_W'(({1'b0, len_cur} + 17'd1) >> 1) * END_W'(4);
  end

  // Checks in priority order.
  always_comb begin
    if (ver_bad_cur) begin
      status_next = STATUS_BAD_VER;
    end else if (fin_crc != image_crc) begin
      status_next = STATUS_BAD_CRC;
    end else if ((len_cur != '0) && (end_addr >= {1'b0, cfg.address_limit})) begin
      status_next = STATUS_BAD_DEST;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // Image state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      word_index     <= '0;
      crc_reg        <= CRC_INIT;
      image_crc      <= '0;
      version_bad    <= 1'b0;
      dest_addr      <= '0;
      payload_length <= '0;
    end else if (advance && in_start) begin
      active      <= 1'b1;
      image_crc   <= in_word;
      crc_reg     <= CRC_INIT;
      word_index  <= IDX_VERSION;
      version_bad <= 1'b0;
    end else if (process) begin
      crc_reg        <= crc_next;
      version_bad    <= ver_bad_cur;
      dest_addr      <= dest_cur;
      payload_length <= len_cur;
      if (done) begin
        active     <= 1'b0;
        word_index <= '0;
      end else begin
        word_index <= word_index + 17'd1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (process && done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && done) begin
      status       <= status_next;
      computed_crc <= fin_crc;
      destination  <= dest_cur;
      length       <= len_cur;
    end
  end

endmodule

/* design/firmware_image_crc_checker.sv */
// Top level of the firmware image CRC checker.
// Depends on fic_pkg, fic_regs and fic_tracker.
//
// Usage: image words enter on word/start_req with word_valid; the block holds
// them back with word_stall. A start-marked word carries the expected CRC,
// then come version, destination, header (length in the low 16 bits) and
// length payload words. After the last word of an image one transaction
// leaves on status/computed_crc/destination/length with result_valid, and
// the receiver holds it with result_stall. Words outside an image give none.
// The last word of an image passes the input register, then the result
// register. Throughput: one word per cycle unless a result is stalled; the 24
// CRC shift steps of a word form one XOR network between the input register
// and the image state. While a result is stalled, one more word is taken into
// the input register, then word_stall rises until the result leaves.
// Reset: synchronous; clears the image state and both valid flags and loads
// expected_version = 1 and address_limit = 0xAF00. Registers sit at byte
// addresses 0 and 4 of the APB-style port; pready is always high.
module firmware_image_crc_checker
  import fic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic [WORD_W-1:0] word,
  input  logic              start_req,
  input  logic              word_valid,
  output logic              word_stall,
  output logic [1:0]        status,
  output logic [WORD_W-1:0] computed_crc,
  output logic [WORD_W-1:0] destination,
  output logic [LEN_W-1:0]  length,
  output logic              result_valid,
  input  logic              result_stall
);

  cfg_t cfg;

  assign pready = 1'b1;

  fic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fic_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .word         (word),
    .start_req    (start_req),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .status       (status),
    .computed_crc (computed_crc),
    .destination  (destination),
    .length       (length),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

/* design/fic_checker.sv */
// Port-level assertions for the firmware image CRC checker, bound to the top level.
// Depends on fic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fic_checker
  import fic_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              word_stall,
  input logic [1:0]        status,
  input logic [WORD_W-1:0] computed_crc,
  input logic [LEN_W-1:0]  length,
  input logic              result_valid,
  input logic              result_stall
);

  // A stalled result transaction stays offered.
  `ASSERT_CLK(a_result_held, result_valid && result_stall |=> result_valid)

  // A stalled result keeps its CRC and status.
  `ASSERT_CLK(a_result_stable, result_valid && result_stall |=> $stable({status, computed_crc}))

  // An image without payload never fails the destination check.
  `ASSERT_CLK(a_zero_len_dest, result_valid && (length == '0) |-> status != STATUS_BAD_DEST)

  // Reset empties the result register and the input register.
  `ASSERT_CLK_ALWAYS(a_reset_clear, rst |=> !result_valid && !word_stall)

endmodule

bind firmware_image_crc_checker fic_checker u_fic_checker (.*);
